// File: design/sit_pkg.sv
// Shared types and widths for the segment intersection test block.
// Depends on nothing; every other file but sit_mul refers to it by scoped names.
package sit_pkg;

  localparam int unsigned COORD_WIDTH = 32;              // signed Q16.16 coordinate
  localparam int unsigned TOL_WIDTH   = 31;              // unsigned Q15.16 tolerance
  localparam int unsigned DIFF_WIDTH  = COORD_WIDTH + 1; // difference of two coordinates
  localparam int unsigned PROD_WIDTH  = 2 * DIFF_WIDTH;  // product of two differences
  localparam int unsigned SUM_WIDTH   = PROD_WIDTH + 1;  // sum of two products, signed
  localparam int unsigned TOL2_WIDTH  = 2 * TOL_WIDTH;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(66);

  typedef logic signed [DIFF_WIDTH-1:0] diff_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_start_u;
    logic signed [COORD_WIDTH-1:0] a_start_v;
    logic signed [COORD_WIDTH-1:0] a_end_u;
    logic signed [COORD_WIDTH-1:0] a_end_v;
    logic signed [COORD_WIDTH-1:0] b_start_u;
    logic signed [COORD_WIDTH-1:0] b_start_v;
    logic signed [COORD_WIDTH-1:0] b_end_u;
    logic signed [COORD_WIDTH-1:0] b_end_v;
  } in_beat_t;

  typedef struct packed {
    logic crosses;
    logic was_parallel;
  } out_beat_t;

  // Vectors of one point-to-segment check: w = p - q0, e = p - q1, d = q1 - q0.
  typedef struct packed {
    diff_t wu;
    diff_t wv;
    diff_t eu;
    diff_t ev;
    diff_t du;
    diff_t dv;
  } near_vec_t;

  typedef struct packed {
    logic parallel;
    logic hit;
  } cross_flags_t;

endpackage

// File: design/sit_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
// Stand-alone; used by sit_near for the wide squared-distance products.
module sit_mul #(
  parameter int unsigned AW = 66,
  parameter int unsigned BW = 66
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  output logic [AW+BW-1:0]   p_o
);

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic [AL+BL-1:0] ll_q;
  logic [AL+BH-1:0] lh_q;
  logic [AH+BL-1:0] hl_q;
  logic [AH+BH-1:0] hh_q;
  logic [PW-1:0]    p_q;

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[AL-1:0]  * b_i[BL-1:0];
      lh_q <= a_i[AL-1:0]  * b_i[BW-1:BL];
      hl_q <= a_i[AW-1:AL] * b_i[BL-1:0];
      hh_q <= a_i[AW-1:AL] * b_i[BW-1:BL];
    end
  end

  // recombine
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PW'(ll_q) + (PW'(lh_q) << BL) + (PW'(hl_q) << AL) + (PW'(hh_q) << (AL + BL));
    end
  end

  assign p_o = p_q;

endmodule

// File: design/sit_near.sv
// Pipelined point-to-segment proximity check (four register stages).
// Depends on sit_pkg and sit_mul.
module sit_near (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  sit_pkg::near_vec_t                 vec_i,
  input  logic [sit_pkg::TOL2_WIDTH-1:0]     tol2_i,
  output logic                               near_o
);

  localparam int unsigned PW = sit_pkg::PROD_WIDTH;
  localparam int unsigned SW = sit_pkg::SUM_WIDTH;
  localparam int unsigned TW = sit_pkg::TOL2_WIDTH;

  // stage 2: products
  logic signed [PW-1:0] wd1_q, wd2_q, wx1_q, wx2_q;
  logic signed [PW-1:0] ww1_q, ww2_q, ee1_q, ee2_q, dd1_q, dd2_q;
  // stage 3: sums
  logic signed [SW-1:0] dot_q, dot_d;
  logic signed [SW-1:0] crs_d;
  logic [PW-1:0]        crs_abs_q, crs_abs_d;
  logic [PW-1:0]        len2_q, len2_d, dw2_q, dw2_d, de2_q, de2_d;
  // stage 4 and 5: selection flags
  logic sel_start_q4, sel_end_q4, near_start_q4, near_end_q4;
  logic sel_start_q5, sel_end_q5, near_start_q5, near_end_q5;
  logic [2*PW-1:0]      sq;
  logic [TW+PW-1:0]     rhs;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wd1_q <= vec_i.wu * vec_i.du;
      wd2_q <= vec_i.wv * vec_i.dv;
      wx1_q <= vec_i.wu * vec_i.dv;
      wx2_q <= vec_i.wv * vec_i.du;
      ww1_q <= vec_i.wu * vec_i.wu;
      ww2_q <= vec_i.wv * vec_i.wv;
      ee1_q <= vec_i.eu * vec_i.eu;
      ee2_q <= vec_i.ev * vec_i.ev;
      dd1_q <= vec_i.du * vec_i.du;
      dd2_q <= vec_i.dv * vec_i.dv;
    end
  end

  always_comb begin
    dot_d     = SW'(wd1_q) + SW'(wd2_q);
    crs_d     = SW'(wx1_q) - SW'(wx2_q);
    crs_abs_d = crs_d[SW-1] ? PW'(-crs_d) : PW'(crs_d);
    len2_d    = $unsigned(dd1_q) + $unsigned(dd2_q);
    dw2_d     = $unsigned(ww1_q) + $unsigned(ww2_q);
    de2_d     = $unsigned(ee1_q) + $unsigned(ee2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q     <= dot_d;
      crs_abs_q <= crs_abs_d;
      len2_q    <= len2_d;
      dw2_q     <= dw2_d;
      de2_q     <= de2_d;
    end
  end

  // clamp decisions: before the start, past the end, or the interior
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_start_q4  <= (len2_q == '0) || dot_q[SW-1] || (dot_q == '0);
      sel_end_q4    <= !dot_q[SW-1] && ($unsigned(dot_q[SW-2:0]) >= len2_q);
      near_start_q4 <= dw2_q <= PW'(tol2_i);
      near_end_q4   <= de2_q <= PW'(tol2_i);
      sel_start_q5  <= sel_start_q4;
      sel_end_q5    <= sel_end_q4;
      near_start_q5 <= near_start_q4;
      near_end_q5   <= near_end_q4;
    end
  end

  sit_mul #(.AW(PW), .BW(PW)) u_sq (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (crs_abs_q),
    .b_i   (crs_abs_q),
    .p_o   (sq)
  );

  sit_mul #(.AW(TW), .BW(PW)) u_rhs (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (tol2_i),
    .b_i   (len2_q),
    .p_o   (rhs)
  );

  always_comb begin
    if (sel_start_q5) begin
      near_o = near_start_q5;
    end else if (sel_end_q5) begin
      near_o = near_end_q5;
    end else begin
      near_o = sq <= (2*PW)'(rhs);
    end
  end

endmodule

// File: design/sit_cross.sv
// Pipelined crossing test of two segments from their cross products.
// Depends on sit_pkg.
module sit_cross (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  sit_pkg::diff_t        d1u_i,
  input  sit_pkg::diff_t        d1v_i,
  input  sit_pkg::diff_t        d2u_i,
  input  sit_pkg::diff_t        d2v_i,
  input  sit_pkg::diff_t        wu_i,
  input  sit_pkg::diff_t        wv_i,
  output sit_pkg::cross_flags_t flags_o
);

  localparam int unsigned PW = sit_pkg::PROD_WIDTH;
  localparam int unsigned SW = sit_pkg::SUM_WIDTH;

  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [SW-1:0] den_q, tn_q, sn_q;
  sit_pkg::cross_flags_t flags_q4, flags_q5, flags_d;

  function automatic logic in_unit(logic signed [SW-1:0] num, logic signed [SW-1:0] den);
    if (den[SW-1]) begin
      return (den <= num) && (num <= 0);
    end
    return (num >= 0) && (num <= den);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= d1u_i * d2v_i;
      p1_q <= d1v_i * d2u_i;
      p2_q <= wu_i * d2v_i;
      p3_q <= wv_i * d2u_i;
      p4_q <= wu_i * d1v_i;
      p5_q <= wv_i * d1u_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= SW'(p0_q) - SW'(p1_q);
      tn_q  <= SW'(p2_q) - SW'(p3_q);
      sn_q  <= SW'(p4_q) - SW'(p5_q);
    end
  end

  always_comb begin
    flags_d.parallel = (den_q == '0);
    flags_d.hit      = in_unit(tn_q, den_q) && in_unit(sn_q, den_q);
  end

  // hold the flags through extra stages (flags_q4, flags_q5) to line up with the proximity checks
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q4 <= flags_d;
      flags_q5 <= flags_q4;
    end
  end

  assign flags_o = flags_q5;

endmodule

// File: design/segment_intersection_test.sv
// Top level of the segment intersection test pipeline.
// Depends on sit_pkg, sit_cross, sit_near and sit_mul.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i): one beat carries the
//   endpoints of segments A and B as signed Q16.16 coordinates.
//   Output channel (out_valid_o / out_ready_i / out_data_o): one beat per input
//   beat, in order: crosses (segments meet, endpoint touch included) and
//   was_parallel (cross-product denominator was exactly zero, so the endpoint
//   tolerance test decided).
//   Tolerance register: written by tolerance_we_i / tolerance_i;
//   write it only while the pipeline is empty. Resets to 66 (about 1 um).
// Timing:
//   One beat per cycle is taken as long as the receiver keeps up; the rate is
//   set by the single pipeline enable shared by all six stages.
//   The wide squared-distance products are split into partial products over
//   two of the stages.
// Reset clears all valid bits; the pipeline starts empty and ready.
// Stall: when out_valid_o is high and out_ready_i low, every stage holds and
//   in_ready_o drops in the same cycle; nothing is lost or repeated.
module segment_intersection_test (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sit_pkg::in_beat_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sit_pkg::out_beat_t               out_data_o,
  input  logic                             tolerance_we_i,
  input  logic [sit_pkg::TOL_WIDTH-1:0]    tolerance_i
);

  localparam int unsigned DW = sit_pkg::DIFF_WIDTH;
  localparam int unsigned NUM_STAGES = 5;

  logic                               en;
  logic [NUM_STAGES-1:0]              v_q;
  logic                               out_valid_q;
  sit_pkg::out_beat_t                 out_data_q, out_data_d;
  logic [sit_pkg::TOL_WIDTH-1:0]      tol_q;
  logic [sit_pkg::TOL2_WIDTH-1:0]     tol2_q;

  // stage 1 vectors
  sit_pkg::diff_t      d1u_q, d1v_q, d2u_q, d2v_q, wu_q, wv_q;
  sit_pkg::near_vec_t  vec_q [4];
  sit_pkg::near_vec_t  vec_d [4];
  logic [3:0]          near;
  sit_pkg::cross_flags_t cflags;

  // advance every stage together unless a finished beat is waiting and not taken
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= sit_pkg::TOL_RESET;
    end else if (tolerance_we_i) begin
      tol_q <= tolerance_i;
    end
  end

  // tol^2 each cycle; user keeps it static while items are in flight; unchecked
  always_ff @(posedge clk_i) begin
    tol2_q <= tol_q * tol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[NUM_STAGES-2:0], in_valid_i};
      out_valid_q <= v_q[NUM_STAGES-1];
    end
  end

  // stage 1: sign-extend and form all differences
  always_comb begin
    sit_pkg::diff_t a0u, a0v, a1u, a1v, b0u, b0v, b1u, b1v;
    a0u = DW'(in_data_i.a_start_u);
    a0v = DW'(in_data_i.a_start_v);
    a1u = DW'(in_data_i.a_end_u);
    a1v = DW'(in_data_i.a_end_v);
    b0u = DW'(in_data_i.b_start_u);
    b0v = DW'(in_data_i.b_start_v);
    b1u = DW'(in_data_i.b_end_u);
    b1v = DW'(in_data_i.b_end_v);
    // A endpoints against segment B
    vec_d[0] = '{wu: a0u - b0u, wv: a0v - b0v, eu: a0u - b1u, ev: a0v - b1v,
                 du: b1u - b0u, dv: b1v - b0v};
    vec_d[1] = '{wu: a1u - b0u, wv: a1v - b0v, eu: a1u - b1u, ev: a1v - b1v,
                 du: b1u - b0u, dv: b1v - b0v};
    // B endpoints against segment A
    vec_d[2] = '{wu: b0u - a0u, wv: b0v - a0v, eu: b0u - a1u, ev: b0v - a1v,
                 du: a1u - a0u, dv: a1v - a0v};
    vec_d[3] = '{wu: b1u - a0u, wv: b1v - a0v, eu: b1u - a1u, ev: b1v - a1v,
                 du: a1u - a0u, dv: a1v - a0v};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1u_q <= vec_d[2].du;
      d1v_q <= vec_d[2].dv;
      d2u_q <= vec_d[0].du;
      d2v_q <= vec_d[0].dv;
      wu_q  <= vec_d[2].wu;
      wv_q  <= vec_d[2].wv;
      for (int i = 0; i < 4; i++) begin
        vec_q[i] <= vec_d[i];
      end
    end
  end

  sit_cross u_cross (
    .clk_i   (clk_i),
    .en_i    (en),
    .d1u_i   (d1u_q),
    .d1v_i   (d1v_q),
    .d2u_i   (d2u_q),
    .d2v_i   (d2v_q),
    .wu_i    (wu_q),
    .wv_i    (wv_q),
    .flags_o (cflags)
  );

  for (genvar g = 0; g < 4; g++) begin : g_near
    sit_near u_near (
      .clk_i  (clk_i),
      .en_i   (en),
      .vec_i  (vec_q[g]),
      .tol2_i (tol2_q),
      .near_o (near[g])
    );
  end

  // parallel pairs fall back to the endpoint tolerance checks
  always_comb begin
    out_data_d.was_parallel = cflags.parallel;
    out_data_d.crosses      = cflags.parallel ? (|near) : cflags.hit;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // a stall must freeze the valid bits of every stage in v_q
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (v_q == $past(v_q)))
    else $error("pipeline valid bits moved during a stall");

  // a beat in the last stage reaches the output when the pipe advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NUM_STAGES-1] && en) |=> out_valid_o)
    else $error("last-stage beat was dropped");

  // a taken result with nothing behind it empties the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !v_q[NUM_STAGES-1]) |=> !out_valid_o)
    else $error("output beat repeated");
`endif

endmodule
